/* rtl/jrp_pkg.sv */
// Shared constants, codes, state encodings and control structs of the register pool unit.
package jrp_pkg;

  localparam int POOL_SIZE   = 12;
  localparam int REG_W       = 4;
  localparam int NUM_SPECIAL = 3;

  typedef logic [REG_W-1:0] reg_t;
  typedef logic [1:0]       spec_t;

  localparam reg_t  NONE_REG        = '1;
  localparam spec_t NO_SKIP         = 2'd3;
  localparam spec_t SPEC_CC         = 2'd0;
  localparam spec_t SPEC_FPCR       = 2'd1;
  localparam spec_t SPEC_FPSR       = 2'd2;
  localparam spec_t LAST_SPILL_STEP = 2'd2;

  localparam logic [3:0] FN_ALLOC     = 4'd0;
  localparam logic [3:0] FN_FREE      = 4'd1;
  localparam logic [3:0] FN_GET_CTX   = 4'd2;
  localparam logic [3:0] FN_FLUSH_CTX = 4'd3;

  localparam logic [1:0] SUB_GET    = 2'd0;
  localparam logic [1:0] SUB_MODIFY = 2'd1;
  localparam logic [1:0] SUB_STORE  = 2'd2;
  localparam logic [1:0] SUB_FLUSH  = 2'd3;

  typedef enum logic [1:0] {
    ACT_ANSWER,
    ACT_CTX_READ,
    ACT_LOAD,
    ACT_STORE
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_AS_TRY,
    ST_AS_FLUSH,
    ST_AS_RETRY,
    ST_FS_CHECK,
    ST_FS_STORE,
    ST_CG_A,
    ST_CG_B,
    ST_GS_A,
    ST_GS_B,
    ST_GS_C,
    ST_GS_D,
    ST_FINAL
  } state_t;

  typedef enum logic [1:0] {
    AS_RET_TOP,
    AS_RET_CG,
    AS_RET_GS
  } as_ret_t;

  typedef enum logic [1:0] {
    CG_RET_TOP,
    CG_RET_GS_PRE,
    CG_RET_GS_POST
  } cg_ret_t;

  typedef enum logic [1:0] {
    FS_RET_SPILL,
    FS_RET_FLUSH,
    FS_RET_STORE
  } fs_ret_t;

  typedef struct packed {
    logic start_op;
    logic free_op;
    logic flush_ctx;
    logic try_alloc;
    logic alloc_ans;
    logic k_clear;
    logic k_inc;
    logic set_exh;
    logic sp_use_op;
    logic nospill;
    logic sp_clear;
    logic emit_store;
    logic release_sp;
    logic ans_ctx;
    logic cg_finish;
    logic cg_ans;
    logic gs_map;
    logic ans_slot;
    logic emit_load;
    logic emit_final;
    logic set_dirty;
  } cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic       free_any;
    logic       ctx_mapped;
    logic       sp_mapped;
    logic       sp_dirty;
    logic       ra_none;
    logic       skip_hit;
    logic       k_last;
  } status_t;

endpackage

/* rtl/jrp_ctrl.sv */
// Controller state machine that sequences allocation, spilling, holder mapping and result beats.
module jrp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  jrp_pkg::status_t status,
  output jrp_pkg::cmd_t    cmd,
  output logic             busy
);
  import jrp_pkg::*;

  state_t  state, state_next;
  as_ret_t as_ret, as_ret_next;
  cg_ret_t cg_ret, cg_ret_next;
  fs_ret_t fs_ret, fs_ret_next;

  logic       is_special;
  logic       op_fpsr;
  logic [1:0] sub;
  state_t     as_done;
  state_t     cg_done;
  state_t     fs_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      as_ret <= AS_RET_TOP;
      cg_ret <= CG_RET_TOP;
      fs_ret <= FS_RET_FLUSH;
    end else begin
      state  <= state_next;
      as_ret <= as_ret_next;
      cg_ret <= cg_ret_next;
      fs_ret <= fs_ret_next;
    end
  end

  assign is_special = (status.func[3:2] != 2'd0);
  assign op_fpsr    = (status.func[3:2] == 2'd3);
  assign sub        = status.func[1:0];
  assign busy       = (state != ST_IDLE);

  always_comb begin
    unique case (as_ret)
      AS_RET_TOP: as_done = ST_FINAL;
      AS_RET_CG:  as_done = ST_CG_B;
      AS_RET_GS:  as_done = ST_GS_C;
      default:    as_done = ST_FINAL;
    endcase
    unique case (cg_ret)
      CG_RET_TOP:     cg_done = ST_FINAL;
      CG_RET_GS_PRE:  cg_done = ST_GS_B;
      CG_RET_GS_POST: cg_done = ST_GS_D;
      default:        cg_done = ST_FINAL;
    endcase
    fs_done = (fs_ret == FS_RET_SPILL) ? ST_AS_RETRY : ST_FINAL;
  end

  always_comb begin
    cmd           = '0;
    cmd.sp_use_op = 1'b1;
    state_next    = state;
    as_ret_next   = as_ret;
    cg_ret_next   = cg_ret;
    fs_ret_next   = fs_ret;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.start_op = 1'b1;
          state_next   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (is_special) begin
          unique case (sub)
            SUB_GET, SUB_MODIFY: state_next = ST_GS_A;
            SUB_STORE: begin
              fs_ret_next = FS_RET_STORE;
              state_next  = ST_FS_CHECK;
            end
            default: begin
              fs_ret_next = FS_RET_FLUSH;
              state_next  = ST_FS_CHECK;
            end
          endcase
        end else begin
          unique case (status.func)
            FN_ALLOC: begin
              as_ret_next = AS_RET_TOP;
              state_next  = ST_AS_TRY;
            end
            FN_FREE: begin
              cmd.free_op = 1'b1;
              state_next  = ST_FINAL;
            end
            FN_GET_CTX: begin
              cg_ret_next = CG_RET_TOP;
              state_next  = ST_CG_A;
            end
            FN_FLUSH_CTX: begin
              cmd.flush_ctx = 1'b1;
              state_next    = ST_FINAL;
            end
            default: state_next = ST_FINAL;
          endcase
        end
      end
      ST_AS_TRY: begin
        cmd.try_alloc = 1'b1;
        cmd.alloc_ans = (as_ret == AS_RET_TOP);
        if (status.free_any) begin
          state_next = as_done;
        end else begin
          cmd.k_clear = 1'b1;
          state_next  = ST_AS_FLUSH;
        end
      end
      ST_AS_FLUSH: begin
        cmd.sp_use_op = 1'b0;
        if (status.skip_hit) begin
          state_next = ST_AS_RETRY;
        end else begin
          fs_ret_next = FS_RET_SPILL;
          state_next  = ST_FS_CHECK;
        end
      end
      ST_AS_RETRY: begin
        cmd.try_alloc = 1'b1;
        cmd.alloc_ans = (as_ret == AS_RET_TOP);
        priority if (status.free_any) begin
          state_next = as_done;
        end else if (status.k_last) begin
          cmd.set_exh = 1'b1;
          state_next  = as_done;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = ST_AS_FLUSH;
        end
      end
      ST_FS_CHECK: begin
        cmd.sp_use_op = (fs_ret != FS_RET_SPILL);
        if (status.sp_mapped && status.sp_dirty) begin
          cmd.nospill = 1'b1;
          state_next  = ST_FS_STORE;
        end else begin
          cmd.sp_clear = (fs_ret != FS_RET_STORE);
          state_next   = fs_done;
        end
      end
      ST_FS_STORE: begin
        cmd.sp_use_op  = (fs_ret != FS_RET_SPILL);
        cmd.emit_store = 1'b1;
        cmd.release_sp = (fs_ret != FS_RET_STORE);
        cmd.sp_clear   = (fs_ret != FS_RET_STORE);
        state_next     = fs_done;
      end
      ST_CG_A: begin
        if (status.ctx_mapped) begin
          cmd.ans_ctx = (cg_ret == CG_RET_TOP);
          state_next  = cg_done;
        end else begin
          as_ret_next = AS_RET_CG;
          state_next  = ST_AS_TRY;
        end
      end
      ST_CG_B: begin
        cmd.cg_finish = 1'b1;
        cmd.cg_ans    = (cg_ret == CG_RET_TOP);
        state_next    = cg_done;
      end
      ST_GS_A: begin
        priority if (status.sp_mapped) begin
          cmd.ans_slot = 1'b1;
          state_next   = ST_FINAL;
        end else if (op_fpsr) begin
          cg_ret_next = CG_RET_GS_PRE;
          state_next  = ST_CG_A;
        end else begin
          state_next = ST_GS_B;
        end
      end
      ST_GS_B: begin
        as_ret_next = AS_RET_GS;
        state_next  = ST_AS_TRY;
      end
      ST_GS_C: begin
        priority if (status.ra_none) begin
          state_next = ST_FINAL;
        end else if (!op_fpsr) begin
          cmd.gs_map  = 1'b1;
          cg_ret_next = CG_RET_GS_POST;
          state_next  = ST_CG_A;
        end else begin
          cmd.gs_map = 1'b1;
          state_next = ST_GS_D;
        end
      end
      ST_GS_D: begin
        cmd.emit_load = 1'b1;
        state_next    = ST_FINAL;
      end
      ST_FINAL: begin
        cmd.emit_final = 1'b1;
        cmd.set_dirty  = is_special && (sub == SUB_MODIFY);
        state_next     = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/jrp_dpath.sv */
// Datapath holding the allocation map, changed mask, holders, per-operation registers and result beat.
module jrp_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  jrp_pkg::cmd_t                   cmd,
  input  logic [3:0]                      func,
  input  logic [3:0]                      reg_to_free,
  output jrp_pkg::status_t                status,
  output logic                            result_valid,
  output logic [1:0]                      action,
  output logic [1:0]                      special_sel,
  output logic [3:0]                      action_reg,
  output logic [3:0]                      ctx_holder,
  output logic [3:0]                      answer_reg,
  output logic                            exhausted,
  output logic [jrp_pkg::POOL_SIZE-1:0]   changed_bits,
  output logic                            last
);
  import jrp_pkg::*;

  function automatic logic [POOL_SIZE-1:0] reg_bit(reg_t r);
    logic [POOL_SIZE-1:0] b;
    for (int i = 0; i < POOL_SIZE; i++) begin
      b[i] = (r == REG_W'(i));
    end
    return b;
  endfunction

  function automatic spec_t spill_order(spec_t k);
    spec_t s;
    unique case (k)
      2'd0:    s = SPEC_FPCR;
      2'd1:    s = SPEC_FPSR;
      default: s = SPEC_CC;
    endcase
    return s;
  endfunction

  logic [POOL_SIZE-1:0] pool_map, pool_map_next;
  logic [POOL_SIZE-1:0] changed_map, changed_map_next;
  reg_t                 ctx_slot, ctx_slot_next;
  reg_t                 special_slot [NUM_SPECIAL];
  reg_t                 special_slot_next [NUM_SPECIAL];
  logic [NUM_SPECIAL-1:0] special_dirty, special_dirty_next;
  logic [3:0]           func_q, func_q_next;
  reg_t                 rtf, rtf_next;
  reg_t                 ra, ra_next;
  reg_t                 ans, ans_next;
  logic                 exh, exh_next;
  spec_t                k, k_next;

  logic [POOL_SIZE-1:0] free_bits;
  logic [POOL_SIZE-1:0] low_free;
  logic                 free_any;
  reg_t                 low_enc;
  reg_t                 alloc_reg;
  logic                 is_special;
  spec_t                op_sel;
  spec_t                skip;
  spec_t                flush_sel;
  spec_t                sp_idx;
  reg_t                 sp_reg;
  logic                 sp_dirty;
  logic                 ctx_mapped;

  logic    emit;
  action_t em_act;
  spec_t   em_sel;
  reg_t    em_areg;
  reg_t    em_ans;
  logic    em_last;

  always_comb begin
    free_bits = ~pool_map;
    low_free  = free_bits & (~free_bits + POOL_SIZE'(1));
    free_any  = |free_bits;
    low_enc   = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (low_free[i]) begin
        low_enc = low_enc | REG_W'(i);
      end
    end
    alloc_reg  = free_any ? low_enc : NONE_REG;
    is_special = (func_q[3:2] != 2'd0);
    op_sel     = func_q[3:2] - 2'd1;
    skip       = is_special ? op_sel : NO_SKIP;
    flush_sel  = spill_order(k);
    sp_idx     = cmd.sp_use_op ? op_sel : flush_sel;
    sp_reg     = NONE_REG;
    sp_dirty   = 1'b0;
    for (int i = 0; i < NUM_SPECIAL; i++) begin
      if (sp_idx == 2'(i)) begin
        sp_reg   = special_slot[i];
        sp_dirty = special_dirty[i];
      end
    end
    ctx_mapped = (ctx_slot != NONE_REG);
  end

  always_comb begin
    status.func       = func_q;
    status.free_any   = free_any;
    status.ctx_mapped = ctx_mapped;
    status.sp_mapped  = (sp_reg != NONE_REG);
    status.sp_dirty   = sp_dirty;
    status.ra_none    = (ra == NONE_REG);
    status.skip_hit   = (flush_sel == skip);
    status.k_last     = (k == LAST_SPILL_STEP);
  end

  always_comb begin
    pool_map_next      = pool_map;
    changed_map_next   = changed_map;
    ctx_slot_next      = ctx_slot;
    special_slot_next  = special_slot;
    special_dirty_next = special_dirty;
    func_q_next        = func_q;
    rtf_next           = rtf;
    ra_next            = ra;
    ans_next           = ans;
    exh_next           = exh;
    k_next             = k;
    emit               = 1'b0;
    em_act             = ACT_ANSWER;
    em_sel             = SPEC_CC;
    em_areg            = NONE_REG;
    em_ans             = NONE_REG;
    em_last            = 1'b0;

    if (cmd.start_op) begin
      func_q_next = func;
      rtf_next    = reg_to_free;
      exh_next    = 1'b0;
      ans_next    = NONE_REG;
    end
    if (cmd.free_op) begin
      pool_map_next = pool_map_next & ~reg_bit(rtf);
    end
    if (cmd.flush_ctx) begin
      pool_map_next = pool_map_next & ~reg_bit(ctx_slot);
      ctx_slot_next = NONE_REG;
    end
    if (cmd.try_alloc) begin
      pool_map_next    = pool_map_next | low_free;
      changed_map_next = changed_map_next | low_free;
      ra_next          = alloc_reg;
      if (cmd.alloc_ans) begin
        ans_next = alloc_reg;
      end
    end
    if (cmd.k_clear) begin
      k_next = 2'd0;
    end
    if (cmd.k_inc) begin
      k_next = k + 2'd1;
    end
    if (cmd.set_exh) begin
      exh_next = 1'b1;
    end
    if (cmd.nospill && !ctx_mapped) begin
      if (free_any) begin
        pool_map_next    = pool_map_next | low_free;
        changed_map_next = changed_map_next | low_free;
        ctx_slot_next    = alloc_reg;
        emit             = 1'b1;
        em_act           = ACT_CTX_READ;
        em_areg          = alloc_reg;
      end else begin
        exh_next = 1'b1;
      end
    end
    if (cmd.emit_store) begin
      emit    = 1'b1;
      em_act  = ACT_STORE;
      em_sel  = sp_idx;
      em_areg = sp_reg;
    end
    if (cmd.release_sp) begin
      pool_map_next = pool_map_next & ~reg_bit(sp_reg);
    end
    if (cmd.ans_ctx) begin
      ans_next = ctx_slot;
    end
    if (cmd.cg_finish && (ra != NONE_REG)) begin
      if (ctx_mapped) begin
        pool_map_next = pool_map_next & ~reg_bit(ra);
        if (cmd.cg_ans) begin
          ans_next = ctx_slot;
        end
      end else begin
        ctx_slot_next = ra;
        emit          = 1'b1;
        em_act        = ACT_CTX_READ;
        em_areg       = ra;
        if (cmd.cg_ans) begin
          ans_next = ra;
        end
      end
    end
    if (cmd.ans_slot) begin
      ans_next = sp_reg;
    end
    if (cmd.emit_load) begin
      ans_next = sp_reg;
      emit     = 1'b1;
      em_act   = ACT_LOAD;
      em_sel   = sp_idx;
      em_areg  = sp_reg;
    end
    for (int i = 0; i < NUM_SPECIAL; i++) begin
      if (sp_idx == 2'(i)) begin
        if (cmd.sp_clear) begin
          special_slot_next[i]  = NONE_REG;
          special_dirty_next[i] = 1'b0;
        end
        if (cmd.gs_map) begin
          special_slot_next[i]  = ra;
          special_dirty_next[i] = 1'b0;
        end
        if (cmd.set_dirty && (ans != NONE_REG)) begin
          special_dirty_next[i] = 1'b1;
        end
      end
    end
    if (cmd.emit_final) begin
      emit    = 1'b1;
      em_act  = ACT_ANSWER;
      em_sel  = is_special ? op_sel : SPEC_CC;
      em_ans  = ans;
      em_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_map      <= '0;
      changed_map   <= '0;
      ctx_slot      <= NONE_REG;
      special_dirty <= '0;
      for (int i = 0; i < NUM_SPECIAL; i++) begin
        special_slot[i] <= NONE_REG;
      end
      result_valid  <= 1'b0;
    end else begin
      pool_map      <= pool_map_next;
      changed_map   <= changed_map_next;
      ctx_slot      <= ctx_slot_next;
      special_slot  <= special_slot_next;
      special_dirty <= special_dirty_next;
      result_valid  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    func_q <= func_q_next;
    rtf    <= rtf_next;
    ra     <= ra_next;
    ans    <= ans_next;
    exh    <= exh_next;
    k      <= k_next;
    if (emit) begin
      action       <= em_act;
      special_sel  <= em_sel;
      action_reg   <= em_areg;
      ctx_holder   <= ctx_slot_next;
      answer_reg   <= em_ans;
      exhausted    <= exh_next;
      changed_bits <= changed_map_next;
      last         <= em_last;
    end
  end

endmodule

/* rtl/jit_register_pool_with_spill_unit.sv */
// Top level of the scratch register pool with spill of cached special registers.
// An operation is accepted when start is high and busy is low; busy then stays high until
// the cycle in which the final beat appears. Every action and the final answer come out as
// one-cycle beats marked by result_valid, and the receiver cannot hold them off. The
// controller walks the operation one step per cycle: a free or context flush passes only
// through the dispatch and final states, a get of a mapped holder also through one check
// state, and a get that has to allocate and spill runs longer. The longest case is a get of
// an unmapped special with the context also unmapped and the pool full, which spills once
// for the special's own register and once more for the context. Each allocation attempt,
// spill check, store and holder mapping is one step.
module jit_register_pool_with_spill_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [3:0]                     func,
  input  logic [3:0]                     reg_to_free,
  output logic                           result_valid,
  output logic [1:0]                     action,
  output logic [1:0]                     special_sel,
  output logic [3:0]                     action_reg,
  output logic [3:0]                     ctx_holder,
  output logic [3:0]                     answer_reg,
  output logic                           exhausted,
  output logic [jrp_pkg::POOL_SIZE-1:0]  changed_bits,
  output logic                           last
);
  import jrp_pkg::*;

  cmd_t    cmd;
  status_t status;

  jrp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  jrp_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .func         (func),
    .reg_to_free  (reg_to_free),
    .status       (status),
    .result_valid (result_valid),
    .action       (action),
    .special_sel  (special_sel),
    .action_reg   (action_reg),
    .ctx_holder   (ctx_holder),
    .answer_reg   (answer_reg),
    .exhausted    (exhausted),
    .changed_bits (changed_bits),
    .last         (last)
  );

endmodule

/* rtl/jrp_checker.sv */
// Port-level checker for the register pool unit and its bind to the top level.
module jrp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          result_valid,
  input logic [1:0]                    action,
  input logic [3:0]                    action_reg,
  input logic [3:0]                    answer_reg,
  input logic                          last
);
  import jrp_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("An accepted operation did not raise busy.");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid)
    else $error("A beat followed the final beat directly.");

  a_action_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy && (action != ACT_ANSWER) && (answer_reg == NONE_REG))
    else $error("An action beat appeared outside an operation or carried an answer.");

  a_final_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> !busy && (action == ACT_ANSWER) && (action_reg == NONE_REG))
    else $error("The final beat has a bad shape or busy is still high.");

endmodule

bind jit_register_pool_with_spill_unit jrp_checker u_jrp_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .action       (action),
  .action_reg   (action_reg),
  .answer_reg   (answer_reg),
  .last         (last)
);

/* tb/testbench.sv */
// Self-checking testbench for the scratch register pool with spill of cached special registers.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jrp_pkg::*;

  localparam int MAX_BEATS      = 8;
  localparam int RANDOM_OPS     = 250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct {
    action_t               act;
    spec_t                 sel;
    reg_t                  areg;
    reg_t                  ctx;
    reg_t                  ans;
    logic                  exh;
    logic [POOL_SIZE-1:0]  chg;
    logic                  fin;
  } beat_t;

  typedef struct packed {
    logic [3:0] f;
    logic [3:0] rf;
    logic       typed;
    reg_t       ans;
    logic       exh;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [3:0]           func;
  logic [3:0]           reg_to_free;
  logic                 result_valid;
  logic [1:0]           action;
  logic [1:0]           special_sel;
  logic [3:0]           action_reg;
  logic [3:0]           ctx_holder;
  logic [3:0]           answer_reg;
  logic                 exhausted;
  logic [POOL_SIZE-1:0] changed_bits;
  logic                 last;

  logic [POOL_SIZE-1:0] pool_used;
  logic [POOL_SIZE-1:0] ever_used;
  reg_t                 ctx_reg;
  reg_t                 spec_reg [NUM_SPECIAL];
  logic                 spec_dirty [NUM_SPECIAL];
  logic                 exh_now;
  beat_t                op_beats [$];
  beat_t                pending_beats [$];
  int                   errors;
  int                   stall_cycles;

  jit_register_pool_with_spill_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .reg_to_free  (reg_to_free),
    .result_valid (result_valid),
    .action       (action),
    .special_sel  (special_sel),
    .action_reg   (action_reg),
    .ctx_holder   (ctx_holder),
    .answer_reg   (answer_reg),
    .exhausted    (exhausted),
    .changed_bits (changed_bits),
    .last         (last)
  );

  function automatic logic [3:0] spec_fn(spec_t s, logic [1:0] sub);
    logic [1:0] grp;
    grp = s + 2'd1;
    return {grp, sub};
  endfunction

  localparam int DIR_N = 28;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{FN_FREE,                       4'd15, 1'b1, NONE_REG, 1'b0},
    '{spec_fn(SPEC_CC, SUB_FLUSH),   4'd0,  1'b0, NONE_REG, 1'b0},
    '{spec_fn(SPEC_FPSR, SUB_STORE), 4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_ALLOC,                      4'd0,  1'b1, 4'd0,     1'b0},
    '{FN_GET_CTX,                    4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_FLUSH_CTX,                  4'd0,  1'b0, NONE_REG, 1'b0},
    '{spec_fn(SPEC_CC, SUB_MODIFY),  4'd0,  1'b0, NONE_REG, 1'b0},
    '{spec_fn(SPEC_CC, SUB_STORE),   4'd0,  1'b0, NONE_REG, 1'b0},
    '{spec_fn(SPEC_FPCR, SUB_MODIFY),4'd0,  1'b0, NONE_REG, 1'b0},
    '{spec_fn(SPEC_FPSR, SUB_GET),   4'd0,  1'b0, NONE_REG, 1'b0},
    '{spec_fn(SPEC_FPSR, SUB_MODIFY),4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_ALLOC,                      4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_ALLOC,                      4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_ALLOC,                      4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_ALLOC,                      4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_ALLOC,                      4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_ALLOC,                      4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_ALLOC,                      4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_ALLOC,                      4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_ALLOC,                      4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_ALLOC,                      4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_ALLOC,                      4'd15, 1'b1, NONE_REG, 1'b1},
    '{FN_FREE,                       4'd11, 1'b0, NONE_REG, 1'b0},
    '{spec_fn(SPEC_FPCR, SUB_GET),   4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_FLUSH_CTX,                  4'd0,  1'b0, NONE_REG, 1'b0},
    '{FN_ALLOC,                      4'd0,  1'b0, NONE_REG, 1'b0},
    '{spec_fn(SPEC_FPCR, SUB_MODIFY),4'd0,  1'b0, NONE_REG, 1'b0},
    '{spec_fn(SPEC_FPCR, SUB_STORE), 4'd0,  1'b1, NONE_REG, 1'b1}
  };

  function automatic void pool_reset();
    pool_used = '0;
    ever_used = '0;
    ctx_reg   = NONE_REG;
    for (int i = 0; i < NUM_SPECIAL; i++) begin
      spec_reg[i]   = NONE_REG;
      spec_dirty[i] = 1'b0;
    end
  endfunction

  function automatic void put_beat(action_t a, spec_t s, reg_t ar, reg_t an, logic fin);
    beat_t b;
    if (op_beats.size() >= MAX_BEATS) return;
    b.act  = a;
    b.sel  = s;
    b.areg = ar;
    b.ctx  = ctx_reg;
    b.ans  = an;
    b.exh  = exh_now;
    b.chg  = ever_used;
    b.fin  = fin;
    op_beats.push_back(b);
  endfunction

  function automatic reg_t take_lowest();
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (!pool_used[i]) begin
        pool_used[i] = 1'b1;
        ever_used[i] = 1'b1;
        return reg_t'(i);
      end
    end
    return NONE_REG;
  endfunction

  function automatic void give_back(reg_t r);
    if (r < POOL_SIZE) pool_used[r] = 1'b0;
  endfunction

  function automatic void map_ctx_plain();
    reg_t r;
    if (ctx_reg != NONE_REG) return;
    r = take_lowest();
    if (r == NONE_REG) begin
      exh_now = 1'b1;
      return;
    end
    ctx_reg = r;
    put_beat(ACT_CTX_READ, SPEC_CC, r, NONE_REG, 1'b0);
  endfunction

  function automatic void write_back_special(spec_t s);
    if (spec_reg[s] != NONE_REG && spec_dirty[s]) begin
      map_ctx_plain();
      put_beat(ACT_STORE, s, spec_reg[s], NONE_REG, 1'b0);
      give_back(spec_reg[s]);
    end
    spec_reg[s]   = NONE_REG;
    spec_dirty[s] = 1'b0;
  endfunction

  function automatic reg_t grab_with_spill(spec_t skip);
    spec_t spill_order [3];
    reg_t  r;
    spill_order = '{SPEC_FPCR, SPEC_FPSR, SPEC_CC};
    r = take_lowest();
    if (r != NONE_REG) return r;
    for (int k = 0; k < 3; k++) begin
      if (spill_order[k] != skip) write_back_special(spill_order[k]);
      r = take_lowest();
      if (r != NONE_REG) return r;
    end
    exh_now = 1'b1;
    return NONE_REG;
  endfunction

  function automatic reg_t fetch_ctx(spec_t skip);
    reg_t r;
    if (ctx_reg != NONE_REG) return ctx_reg;
    r = grab_with_spill(skip);
    if (r == NONE_REG) return NONE_REG;
    if (ctx_reg != NONE_REG) begin
      give_back(r);
      return ctx_reg;
    end
    ctx_reg = r;
    put_beat(ACT_CTX_READ, SPEC_CC, r, NONE_REG, 1'b0);
    return r;
  endfunction

  function automatic reg_t fetch_special(spec_t s);
    reg_t r;
    if (spec_reg[s] != NONE_REG) return spec_reg[s];
    if (s == SPEC_FPSR) void'(fetch_ctx(s));
    r = grab_with_spill(s);
    if (r == NONE_REG) return NONE_REG;
    spec_reg[s]   = r;
    spec_dirty[s] = 1'b0;
    if (s != SPEC_FPSR) void'(fetch_ctx(s));
    put_beat(ACT_LOAD, s, r, NONE_REG, 1'b0);
    return r;
  endfunction

  function automatic void predict_op(logic [3:0] f, logic [3:0] rf);
    reg_t       ans;
    spec_t      s;
    spec_t      sel;
    logic [1:0] sub;
    op_beats.delete();
    exh_now = 1'b0;
    ans     = NONE_REG;
    sel     = SPEC_CC;
    case (f)
      FN_ALLOC: ans = grab_with_spill(NO_SKIP);
      FN_FREE: give_back(rf);
      FN_GET_CTX: ans = fetch_ctx(NO_SKIP);
      FN_FLUSH_CTX: begin
        if (ctx_reg != NONE_REG) give_back(ctx_reg);
        ctx_reg = NONE_REG;
      end
      default: begin
        s   = spec_t'((f - 4'd4) >> 2);
        sub = f[1:0];
        sel = s;
        case (sub)
          SUB_GET: ans = fetch_special(s);
          SUB_MODIFY: begin
            ans = fetch_special(s);
            if (ans != NONE_REG) spec_dirty[s] = 1'b1;
          end
          SUB_STORE: begin
            if (spec_reg[s] != NONE_REG && spec_dirty[s]) begin
              map_ctx_plain();
              put_beat(ACT_STORE, s, spec_reg[s], NONE_REG, 1'b0);
            end
          end
          default: write_back_special(s);
        endcase
      end
    endcase
    while (op_beats.size() >= MAX_BEATS) op_beats.delete(op_beats.size() - 1);
    put_beat(ACT_ANSWER, sel, NONE_REG, ans, 1'b1);
    foreach (op_beats[i]) pending_beats.push_back(op_beats[i]);
  endfunction

  task automatic send_op(input logic [3:0] f, input logic [3:0] rf, input logic typed,
                         input reg_t exp_ans, input logic exp_exh);
    func        = f;
    reg_to_free = rf;
    start       = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_op(f, rf);
    if (typed) begin
      pending_beats[pending_beats.size() - 1].ans = exp_ans;
      pending_beats[pending_beats.size() - 1].exh = exp_exh;
    end
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 50) len = 0;
    else if (pick < 90) len = $urandom_range(1, 3);
    else len = $urandom_range(10, 40);
    if (len > 0) begin
      start = 1'b0;
      repeat (len) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] expv,
                             input logic [15:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, actual %0d", name, expv, actv);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    beat_t exp_b;
    if (!rst && result_valid) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with no expectation: action %0d answer_reg %0d", action,
               answer_reg);
        errors++;
      end else begin
        exp_b = pending_beats.pop_front();
        check_field("action", 16'(exp_b.act), 16'(action));
        check_field("special_sel", 16'(exp_b.sel), 16'(special_sel));
        check_field("action_reg", 16'(exp_b.areg), 16'(action_reg));
        check_field("ctx_holder", 16'(exp_b.ctx), 16'(ctx_holder));
        check_field("answer_reg", 16'(exp_b.ans), 16'(answer_reg));
        check_field("exhausted", 16'(exp_b.exh), 16'(exhausted));
        check_field("changed_bits", 16'(exp_b.chg), 16'(changed_bits));
        check_field("last", 16'(exp_b.fin), 16'(last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [3:0] f;
    logic [3:0] rf;
    int         pick;
    int         done_ops;
    bit         growing;
    errors       = 0;
    stall_cycles = 0;
    rst          = 1'b1;
    start        = 1'b0;
    func         = FN_ALLOC;
    reg_to_free  = 4'd0;
    pool_reset();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      send_op(DIR_ROWS[i].f, DIR_ROWS[i].rf, DIR_ROWS[i].typed, DIR_ROWS[i].ans,
              DIR_ROWS[i].exh);
      idle_gap();
    end
    wait_drained();

    done_ops = 0;
    growing  = 1'b1;
    while (done_ops < RANDOM_OPS) begin
      if ($urandom_range(0, 39) == 0) growing = !growing;
      pick = $urandom_range(0, 99);
      rf   = 4'($urandom_range(0, 15));
      if (pick < (growing ? 35 : 10)) begin
        f = FN_ALLOC;
      end else if (pick < 45) begin
        f  = FN_FREE;
        rf = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(POOL_SIZE, 15))
                                         : 4'($urandom_range(0, POOL_SIZE - 1));
      end else if (pick < 52) begin
        f = FN_GET_CTX;
      end else if (pick < 57) begin
        f = FN_FLUSH_CTX;
      end else begin
        f = spec_fn(spec_t'($urandom_range(0, 2)), 2'($urandom_range(0, 3)));
      end
      send_op(f, rf, 1'b0, NONE_REG, 1'b0);
      if (!(f == FN_FREE && rf >= POOL_SIZE)) done_ops++;
      if (done_ops == RANDOM_OPS / 2 || $urandom_range(0, 29) == 0) wait_drained();
      idle_gap();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
